// ===== design/onal_pkg.sv =====
// Shared types, codes and defaults for the object number allocator.
// No dependencies; every other file of the block but onal_ram imports this package.
package onal_pkg;

    localparam int DEF_FREE_DEPTH     = 64;
    localparam int DEF_RETIRED_DEPTH  = 16;
    localparam int DEF_MAX_OBJECTS    = 8388607;
    localparam int DEF_MAX_GENERATION = 65535;

    localparam int NUM_W = 23;
    localparam int GEN_W = 16;
    localparam int KEY_W = NUM_W + GEN_W;

    localparam logic [2:0] CMD_ALLOC     = 3'd0;
    localparam logic [2:0] CMD_RELEASE   = 3'd1;
    localparam logic [2:0] CMD_ADD_FREE  = 3'd2;
    localparam logic [2:0] CMD_NOTE_USED = 3'd3;
    localparam logic [2:0] CMD_RESET_CNT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_RETIRED   = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [2:0]       command;
        logic [NUM_W-1:0] object_number;
        logic [GEN_W-1:0] generation;
    } t_in_word;

    typedef struct packed {
        logic [NUM_W-1:0] given_number;
        logic [GEN_W-1:0] given_generation;
        logic [2:0]       status;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic cand_next;
        logic cand_inc;
        logic ridx_clr;
        logic ridx_inc;
        logic ret_wr;
        logic fidx_inc;
        logic shift_start;
        logic shift_rd;
        logic fidx_dec;
        logic free_wr_shift;
        logic free_wr_key;
        logic pop;
        logic res_alloc;
        logic res_fail;
        logic res_retired;
        logic res_full;
        logic res_dup;
        logic res_echo;
        logic note;
        logic cnt_reset;
        logic out_load;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       pop_ok;
        logic       gen_ge_max;
        logic       cand_limit;
        logic       ridx_end;
        logic       rhit;
        logic       ret_full;
        logic       fidx_end;
        logic       f_eq;
        logic       f_gt;
        logic       free_full;
        logic       at_pos;
        logic       out_free;
    } t_sts;

endpackage

// ===== design/onal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module onal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/onal_ctrl.sv =====
// Controller state machine of the object number allocator.
// Depends on onal_pkg; drives t_ctl to the datapath, reads t_sts back.
module onal_ctrl
    import onal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_POP    = 12'b0000_0000_0100,
        S_ACHK   = 12'b0000_0000_1000,
        S_RRD    = 12'b0000_0001_0000,
        S_RCMP   = 12'b0000_0010_0000,
        S_FRD    = 12'b0000_0100_0000,
        S_FCMP   = 12'b0000_1000_0000,
        S_FPOS   = 12'b0001_0000_0000,
        S_SHRD   = 12'b0010_0000_0000,
        S_SHWR   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   w_is_alloc;

    assign w_is_alloc = (i_sts.cmd == CMD_ALLOC);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_ALLOC: begin
                        if (i_sts.pop_ok) begin
                            n_state = S_POP;
                        end else begin
                            o_ctl.cand_next = 1'b1;
                            n_state         = S_ACHK;
                        end
                    end
                    CMD_RELEASE, CMD_ADD_FREE: begin
                        n_state = i_sts.gen_ge_max ? S_RRD : S_FRD;
                    end
                    CMD_NOTE_USED: begin
                        o_ctl.note     = 1'b1;
                        o_ctl.res_echo = 1'b1;
                        n_state        = S_DONE;
                    end
                    CMD_RESET_CNT: begin
                        o_ctl.cnt_reset = 1'b1;
                        o_ctl.res_echo  = 1'b1;
                        n_state         = S_DONE;
                    end
                    default: begin
                        o_ctl.res_echo = 1'b1;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_POP: begin
                o_ctl.pop = 1'b1;
                n_state   = S_DONE;
            end
            S_ACHK: begin
                o_ctl.ridx_clr = 1'b1;
                if (i_sts.cand_limit) begin
                    o_ctl.res_fail = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                if (!i_sts.ridx_end) begin
                    n_state = S_RCMP;
                end else begin
                    n_state = S_DONE;
                    if (w_is_alloc) begin
                        o_ctl.res_alloc = 1'b1;
                    end else if (i_sts.ret_full) begin
                        o_ctl.res_full = 1'b1;
                    end else begin
                        o_ctl.ret_wr      = 1'b1;
                        o_ctl.res_retired = 1'b1;
                    end
                end
            end
            S_RCMP: begin
                if (!i_sts.rhit) begin
                    o_ctl.ridx_inc = 1'b1;
                    n_state        = S_RRD;
                end else if (w_is_alloc) begin
                    // candidate is retired: try the next number
                    o_ctl.cand_inc = 1'b1;
                    n_state        = S_ACHK;
                end else begin
                    o_ctl.res_retired = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_FRD: begin
                n_state = i_sts.fidx_end ? S_FPOS : S_FCMP;
            end
            S_FCMP: begin
                if (i_sts.f_eq) begin
                    o_ctl.res_dup = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.f_gt) begin
                    n_state = S_FPOS;
                end else begin
                    o_ctl.fidx_inc = 1'b1;
                    n_state        = S_FRD;
                end
            end
            S_FPOS: begin
                if (i_sts.free_full) begin
                    o_ctl.res_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_ctl.shift_start = 1'b1;
                    n_state           = S_SHRD;
                end
            end
            S_SHRD: begin
                o_ctl.shift_rd = 1'b1;
                if (i_sts.at_pos) begin
                    o_ctl.free_wr_key = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_ctl.free_wr_shift = 1'b1;
                o_ctl.fidx_dec      = 1'b1;
                n_state             = S_SHRD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state register not one-hot");
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");
    a_done_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |=> (r_state == S_IDLE))
        else $error("no return to idle after result");

endmodule

// ===== design/onal_dp.sv =====
// Datapath of the object number allocator: free list ring, retired store,
// counter, result and output registers. Depends on onal_pkg and onal_ram.
module onal_dp
    import onal_pkg::*;
#(
    parameter int FREE_DEPTH     = DEF_FREE_DEPTH,
    parameter int RETIRED_DEPTH  = DEF_RETIRED_DEPTH,
    parameter int MAX_OBJECTS    = DEF_MAX_OBJECTS,
    parameter int MAX_GENERATION = DEF_MAX_GENERATION
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    output t_sts      o_sts,
    input  t_in_word  i_in_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_data
);

    localparam int FA = $clog2(FREE_DEPTH);
    localparam int FC = $clog2(FREE_DEPTH + 1);
    localparam int RA = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
    localparam int RC = $clog2(RETIRED_DEPTH + 1);

    logic [2:0]       r_cmd;
    logic [NUM_W-1:0] r_num;
    logic [GEN_W-1:0] r_gen;
    logic [NUM_W-1:0] r_cand;
    logic [NUM_W-1:0] r_next;
    logic             r_reuse;
    logic [FA-1:0]    r_head;
    logic [FC-1:0]    r_fcount;
    logic [FC-1:0]    r_fidx;
    logic [FC-1:0]    r_pos;
    logic [RC-1:0]    r_rcount;
    logic [RC-1:0]    r_ridx;
    t_out_word        r_res;

    logic [GEN_W:0]   w_gen_eff;
    logic [KEY_W-1:0] w_key;
    logic [FC-1:0]    w_roff;
    logic [FA-1:0]    w_fraddr;
    logic [FA-1:0]    w_fwaddr;
    logic             w_fwe;
    logic [KEY_W-1:0] w_fwdata;
    logic [KEY_W-1:0] w_frdata;
    logic [NUM_W-1:0] w_rrdata;
    logic             w_bump;
    logic [NUM_W-1:0] w_bump_num;
    logic [NUM_W:0]   w_bump_inc;
    logic [NUM_W:0]   w_cand_inc;

    function automatic logic [FA-1:0] wrap(input logic [FC:0] s);
        logic [FC:0] t;
        t = (s >= (FC+1)'(FREE_DEPTH)) ? s - (FC+1)'(FREE_DEPTH) : s;
        return t[FA-1:0];
    endfunction

    assign w_gen_eff = {1'b0, r_gen} + (GEN_W+1)'(r_cmd == CMD_RELEASE);
    assign w_key     = {r_num, w_gen_eff[GEN_W-1:0]};
    assign w_roff    = i_ctl.shift_rd ? r_fidx - FC'(1) : r_fidx;
    assign w_fraddr  = wrap((FC+1)'(r_head) + (FC+1)'(w_roff));
    assign w_fwaddr  = wrap((FC+1)'(r_head) + (FC+1)'(r_fidx));
    assign w_fwe     = i_ctl.free_wr_shift | i_ctl.free_wr_key;
    assign w_fwdata  = i_ctl.free_wr_key ? w_key : w_frdata;
    assign w_cand_inc = {1'b0, r_cand} + (NUM_W+1)'(1);

    onal_ram #(.WIDTH(KEY_W), .DEPTH(FREE_DEPTH), .AW(FA)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_fwaddr),
        .i_wdata (w_fwdata),
        .i_raddr (w_fraddr),
        .o_rdata (w_frdata)
    );

    onal_ram #(.WIDTH(NUM_W), .DEPTH(RETIRED_DEPTH), .AW(RA)) u_ret_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.ret_wr),
        .i_waddr (r_rcount[RA-1:0]),
        .i_wdata (r_num),
        .i_raddr (r_ridx[RA-1:0]),
        .o_rdata (w_rrdata)
    );

    // counter advance: pop, allocate from counter, insert or note used
    assign w_bump = i_ctl.pop | i_ctl.res_alloc | i_ctl.free_wr_key | i_ctl.note;
    always_comb begin
        if (i_ctl.pop) begin
            w_bump_num = w_frdata[KEY_W-1:GEN_W];
        end else if (i_ctl.res_alloc) begin
            w_bump_num = r_cand;
        end else begin
            w_bump_num = r_num;
        end
    end
    assign w_bump_inc = {1'b0, w_bump_num} + (NUM_W+1)'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_cmd;
        o_sts.pop_ok     = r_reuse && (r_fcount != '0);
        o_sts.gen_ge_max = w_gen_eff >= (GEN_W+1)'(MAX_GENERATION);
        o_sts.cand_limit = w_cand_inc >= (NUM_W+1)'(MAX_OBJECTS);
        o_sts.ridx_end   = (r_ridx == r_rcount);
        o_sts.rhit       = (w_rrdata == r_cand);
        o_sts.ret_full   = r_rcount >= RC'(RETIRED_DEPTH);
        o_sts.fidx_end   = (r_fidx == r_fcount);
        o_sts.f_eq       = (w_frdata == w_key);
        o_sts.f_gt       = (w_frdata > w_key);
        o_sts.free_full  = r_fcount >= FC'(FREE_DEPTH);
        o_sts.at_pos     = (r_fidx == r_pos);
        o_sts.out_free   = !o_out_valid || i_out_ready;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd  <= i_in_data.command;
            r_num  <= i_in_data.object_number;
            r_gen  <= i_in_data.generation;
            r_cand <= i_in_data.object_number;
        end else if (i_ctl.cand_next) begin
            r_cand <= r_next;
        end else if (i_ctl.cand_inc) begin
            r_cand <= w_cand_inc[NUM_W-1:0];
        end

        if (i_ctl.shift_start) begin
            r_pos <= r_fidx;
        end

        if (i_ctl.pop) begin
            r_res <= '{w_frdata[KEY_W-1:GEN_W], w_frdata[GEN_W-1:0], ST_OK};
        end else if (i_ctl.res_alloc) begin
            r_res <= '{r_cand, '0, ST_OK};
        end else if (i_ctl.res_fail) begin
            r_res <= '{r_num, '0, ST_EXHAUSTED};
        end else if (i_ctl.res_retired) begin
            r_res <= '{r_num, '0, ST_RETIRED};
        end else if (i_ctl.res_full) begin
            r_res <= '{r_num, '0, ST_FULL};
        end else if (i_ctl.res_dup) begin
            r_res <= '{r_num, w_gen_eff[GEN_W-1:0], ST_DUPLICATE};
        end else if (i_ctl.free_wr_key) begin
            r_res <= '{r_num, w_gen_eff[GEN_W-1:0], ST_OK};
        end else if (i_ctl.res_echo) begin
            r_res <= '{r_num, r_gen, ST_OK};
        end

        if (i_ctl.out_load) begin
            o_out_data <= r_res;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next      <= NUM_W'(1);
            r_reuse     <= 1'b1;
            r_head      <= '0;
            r_fcount    <= '0;
            r_fidx      <= '0;
            r_rcount    <= '0;
            r_ridx      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_ctl.load_in || i_ctl.ridx_clr) begin
                r_ridx <= '0;
            end else if (i_ctl.ridx_inc) begin
                r_ridx <= r_ridx + RC'(1);
            end

            if (i_ctl.load_in) begin
                r_fidx <= '0;
            end else if (i_ctl.fidx_inc) begin
                r_fidx <= r_fidx + FC'(1);
            end else if (i_ctl.shift_start) begin
                r_fidx <= r_fcount;
            end else if (i_ctl.fidx_dec) begin
                r_fidx <= r_fidx - FC'(1);
            end

            if (i_ctl.ret_wr) begin
                r_rcount <= r_rcount + RC'(1);
            end

            if (i_ctl.pop) begin
                r_head   <= wrap((FC+1)'(r_head) + (FC+1)'(1));
                r_fcount <= r_fcount - FC'(1);
            end else if (i_ctl.free_wr_key) begin
                r_fcount <= r_fcount + FC'(1);
            end

            if (i_ctl.cnt_reset) begin
                r_next <= NUM_W'(1);
            end else if (w_bump && (w_bump_num >= r_next)) begin
                // clamp at the object limit
                if (w_bump_inc > (NUM_W+1)'(MAX_OBJECTS)) begin
                    r_next <= NUM_W'(MAX_OBJECTS);
                end else begin
                    r_next <= w_bump_inc[NUM_W-1:0];
                end
            end

            if (i_cfg_valid) begin
                r_reuse <= i_cfg_data;
                if (!i_cfg_data) begin
                    r_fcount <= '0;
                end
            end

            if (i_ctl.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_fcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcount <= FC'(FREE_DEPTH))
        else $error("free list count beyond depth");
    a_rcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= RC'(RETIRED_DEPTH))
        else $error("retired count beyond depth");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != '0) && (r_next <= NUM_W'(MAX_OBJECTS)))
        else $error("next number out of range");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |=> o_out_valid)
        else $error("result word lost");

endmodule

// ===== design/object_number_allocator_top.sv =====
// Top level of the object number allocator: controller plus datapath.
// Depends on onal_pkg, onal_ctrl, onal_dp (and onal_ram below it).
//
//  channel  direction  handshake                  word
//  in       input      i_in_valid / o_in_ready    t_in_word  i_in_data
//  out      output     o_out_valid / i_out_ready  t_out_word o_out_data
//  cfg      input      i_cfg_valid / o_cfg_ready  reuse_enable i_cfg_data
//
// One word at a time. Note used and reset counter pass decode and done; pop
// passes decode, pop and done. Insert reads and compares each free entry
// scanned, then reads and writes each one shifted (free list RAM, one read
// port). Counter allocation compares each retired entry, per number skipped.
// Synchronous active-low reset; no clearing pass. The next word is taken
// while a result waits in the output register; a stalled output holds
// only the final step.
module object_number_allocator_top
    import onal_pkg::*;
#(
    parameter int FREE_DEPTH     = DEF_FREE_DEPTH,
    parameter int RETIRED_DEPTH  = DEF_RETIRED_DEPTH,
    parameter int MAX_OBJECTS    = DEF_MAX_OBJECTS,
    parameter int MAX_GENERATION = DEF_MAX_GENERATION
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    t_ctl w_ctl;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    onal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    onal_dp #(
        .FREE_DEPTH     (FREE_DEPTH),
        .RETIRED_DEPTH  (RETIRED_DEPTH),
        .MAX_OBJECTS    (MAX_OBJECTS),
        .MAX_GENERATION (MAX_GENERATION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/sv/object_number_allocator_top_tb.sv =====
// Testbench for object_number_allocator_top: random and directed commands
// checked against an in-bench model of the free list, retired store and counter.
// Depends on onal_pkg and the allocator RTL.
module object_number_allocator_top_tb;
    import onal_pkg::*;

    localparam int FREE_D  = DEF_FREE_DEPTH;
    localparam int RET_D   = DEF_RETIRED_DEPTH;
    localparam int MAX_OBJ = DEF_MAX_OBJECTS;
    localparam int MAX_GEN = DEF_MAX_GENERATION;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int QCAP = 4096;
    localparam int HOLD_CYCLES = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    object_number_allocator_top u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // allocator model state
    logic [KEY_W-1:0] free_list[FREE_D];
    int               free_cnt;
    logic [NUM_W-1:0] retired[RET_D];
    int               retired_cnt;
    int               next_num;
    bit               reuse_on;

    // pending input words and expected result words, read from head to tail
    t_in_word  pend_mem[QCAP];
    int        pend_head = 0;
    int        pend_tail = 0;
    t_out_word exp_mem[QCAP];
    int        exp_head = 0;
    int        exp_tail = 0;
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_off;
    int        hold_cycles = 0;
    longint    cycles;

    function automatic void bump_next(int num);
        if (num >= next_num) next_num = (num + 1 > MAX_OBJ) ? MAX_OBJ : num + 1;
    endfunction

    function automatic bit number_retired(int num);
        for (int i = 0; i < retired_cnt; i++)
            if (retired[i] == num) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [2:0] insert_free(int num, int gen, output int gen_out);
        logic [KEY_W-1:0] key;
        int pos;
        gen_out = 0;
        if (gen >= MAX_GEN) begin
            if (number_retired(num)) return ST_RETIRED;
            if (retired_cnt >= RET_D) return ST_FULL;
            retired[retired_cnt] = num;
            retired_cnt++;
            return ST_RETIRED;
        end
        key = {num[NUM_W-1:0], gen[GEN_W-1:0]};
        pos = 0;
        while (pos < free_cnt && free_list[pos] < key) pos++;
        if (pos < free_cnt && free_list[pos] == key) begin
            gen_out = gen;
            return ST_DUPLICATE;
        end
        if (free_cnt >= FREE_D) return ST_FULL;
        for (int i = free_cnt; i > pos; i--) free_list[i] = free_list[i-1];
        free_list[pos] = key;
        free_cnt++;
        bump_next(num);
        gen_out = gen;
        return ST_OK;
    endfunction

    function automatic t_out_word allocate_result(t_in_word w);
        t_out_word r;
        int onum, ogen, n;
        onum = w.object_number;
        ogen = w.generation;
        r.status = ST_OK;
        case (w.command)
            CMD_ALLOC: begin
                ogen = 0;
                if (reuse_on && free_cnt > 0) begin
                    onum = free_list[0][KEY_W-1:GEN_W];
                    ogen = free_list[0][GEN_W-1:0];
                    for (int i = 1; i < free_cnt; i++) free_list[i-1] = free_list[i];
                    free_cnt--;
                    bump_next(onum);
                end else begin
                    n = next_num;
                    while (n + 1 < MAX_OBJ && number_retired(n)) n++;
                    if (n + 1 >= MAX_OBJ) r.status = ST_EXHAUSTED;
                    else begin
                        onum = n;
                        bump_next(n);
                    end
                end
            end
            CMD_RELEASE:   r.status = insert_free(w.object_number, w.generation + 1, ogen);
            CMD_ADD_FREE:  r.status = insert_free(w.object_number, w.generation, ogen);
            CMD_NOTE_USED: bump_next(w.object_number);
            CMD_RESET_CNT: next_num = 1;
            default: ;
        endcase
        r.given_number = onum[NUM_W-1:0];
        r.given_generation = ogen[GEN_W-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    task automatic add_word(t_in_word w);
        pend_mem[pend_tail] = w;
        pend_tail++;
    endtask

    // driver: accepted words are predicted at the edge that takes them
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            exp_mem[exp_tail] = allocate_result(i_in_data);
            exp_tail++;
            pend_head++;
        end
        if (i_cfg_valid && o_cfg_ready) begin
            reuse_on = i_cfg_data;
            if (!reuse_on) free_cnt = 0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_in_valid <= 1'b0;
        else if (!(i_in_valid && !o_in_ready)) begin
            // hold the word until taken; otherwise offer the next or idle
            if (pend_tail > pend_head && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pend_mem[pend_head];
            end else i_in_valid <= 1'b0;
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // receiver stall: count the held-off cycles, then release
    always @(posedge i_clk) begin
        if (hold_off) begin
            hold_cycles++;
            if (hold_cycles >= HOLD_CYCLES) begin
                hold_off = 1'b0;
                hold_cycles = 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (o_out_valid && i_out_ready) begin
            if (exp_tail == exp_head) report("unexpected word", 0, 0);
            else begin
                t_out_word e;
                e = exp_mem[exp_head];
                exp_head++;
                if (o_out_data.given_number !== e.given_number)
                    report("given_number", o_out_data.given_number, e.given_number);
                if (o_out_data.given_generation !== e.given_generation)
                    report("given_generation", o_out_data.given_generation,
                        e.given_generation);
                if (o_out_data.status !== e.status)
                    report("status", o_out_data.status, e.status);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_in_word word_of(logic [2:0] c, int num, int gen);
        t_in_word w;
        w.command = c;
        w.object_number = num[NUM_W-1:0];
        w.generation = gen[GEN_W-1:0];
        return w;
    endfunction

    function automatic int pick_num();
        case ($urandom_range(9))
            0: return $urandom_range(MAX_OBJ);
            1: return MAX_OBJ - $urandom_range(3);
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic int pick_gen();
        case ($urandom_range(11))
            0: return MAX_GEN;
            1: return MAX_GEN - 1;
            2: return $urandom_range(MAX_GEN);
            default: return $urandom_range(3);
        endcase
    endfunction

    task automatic drain();
        while (pend_tail > pend_head || exp_tail > exp_head) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reuse(bit v);
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(int count);
        int c;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(99);
            if (c < 35) add_word(word_of(CMD_ALLOC, pick_num(), pick_gen()));
            else if (c < 60)
                add_word(word_of(CMD_RELEASE, pick_num(), pick_gen()));
            else if (c < 82)
                add_word(word_of(CMD_ADD_FREE, pick_num(), pick_gen()));
            else if (c < 90)
                add_word(word_of(CMD_NOTE_USED, pick_num(), pick_gen()));
            else if (c < 95) add_word(word_of(CMD_RESET_CNT, pick_num(), 0));
            else add_word(word_of(3'($urandom_range(7, 5)),
                $urandom_range(MAX_OBJ), $urandom_range(MAX_GEN)));
        end
    endtask

    initial begin
        free_cnt = 0;
        retired_cnt = 0;
        next_num = 1;
        reuse_on = 1'b1;
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 83;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every command, field extremes, retiring, exhaustion
        add_word(word_of(CMD_ALLOC, 0, 0));
        add_word(word_of(CMD_ADD_FREE, 5, 3));
        add_word(word_of(CMD_ADD_FREE, 5, 3));
        add_word(word_of(CMD_ADD_FREE, 2, 9));
        add_word(word_of(CMD_ALLOC, 0, 0));
        add_word(word_of(CMD_RELEASE, 7, MAX_GEN - 1));
        add_word(word_of(CMD_RELEASE, 7, MAX_GEN));
        add_word(word_of(CMD_ADD_FREE, 8, MAX_GEN));
        add_word(word_of(CMD_ADD_FREE, 8, MAX_GEN));
        add_word(word_of(CMD_RESET_CNT, MAX_OBJ, MAX_GEN));
        add_word(word_of(CMD_ALLOC, 0, 0));
        add_word(word_of(CMD_ALLOC, 0, 0));
        add_word(word_of(CMD_NOTE_USED, MAX_OBJ - 3, 0));
        add_word(word_of(CMD_ALLOC, 0, 0));
        add_word(word_of(CMD_NOTE_USED, MAX_OBJ, MAX_GEN));
        add_word(word_of(CMD_ALLOC, MAX_OBJ, MAX_GEN));
        add_word(word_of(3'd7, MAX_OBJ, MAX_GEN));
        add_word(word_of(3'd5, 0, 0));
        add_word(word_of(CMD_RESET_CNT, 0, 0));
        add_word(word_of(CMD_ADD_FREE, MAX_OBJ, 0));
        drain();

        // fill both stores so that the full cases come up
        for (int i = 0; i < 20; i++)
            add_word(word_of(CMD_RELEASE, 100 + i, MAX_GEN - 1));
        for (int i = 0; i < 70; i++)
            add_word(word_of(CMD_ADD_FREE, $urandom_range(200), i));
        drain();

        write_reuse(1'b0);
        random_burst(300);
        drain();
        write_reuse(1'b1);
        random_burst(300);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 7;
        random_burst(500);
        drain();
        write_reuse(1'b0);
        random_burst(150);
        drain();
        write_reuse(1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver stall while words keep coming
        hold_off = 1'b1;
        random_burst(500);
        wait (!hold_off);
        drain();

        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
